FILE: src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/sac_pkg.sv
package sac_pkg;
  localparam int BLOCK_BYTES = 64;
  localparam int SETS = 64;
  localparam int WAYS = 4;
  localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int SET_BITS = $clog2(SETS + 1) - 1;
  localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W = 32 - OFF_BITS - SET_BITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int QDEPTH = 2;

  typedef logic [SET_W-1:0] set_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [WAY_W-1:0] wayidx_t;

  typedef struct packed {
    set_t set;
    tag_t tag;
  } req_t;
endpackage

FILE: src/sac_front.sv
module sac_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [31:0]   in_address,
  output logic          q_valid,
  input  logic          q_pop,
  output sac_pkg::req_t q_req
);
  import sac_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  req_t           mem_r [QDEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;
  logic           push;
  req_t           req;

  always_comb begin
    req.tag = in_address[31 -: TAG_W];
    if (SET_BITS > 0) begin
      req.set = in_address[OFF_BITS +: SET_W];
    end else begin
      req.set = '0;
    end
  end

  assign in_stall = (cnt_r == (PW+1)'(QDEPTH));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != '0);
  assign q_req = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

FILE: src/sac_back.sv
module sac_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_use_lru,
  input  logic          q_valid,
  output logic          q_pop,
  input  sac_pkg::req_t q_req,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_hit,
  output logic [1:0]    out_way,
  output logic          out_evicted,
  output logic [31:0]   out_hit_count,
  output logic [31:0]   out_miss_count
);
  import sac_pkg::*;

  typedef enum logic {S_READ, S_UPD} state_t;
  typedef logic [TAG_W+64-1:0] row_t;
  typedef logic [WAYS-1:0][TAG_W+64-1:0] line_set_t;

  state_t                     state_r;
  logic [SETS-1:0][WAYS-1:0]  valid_r;
  line_set_t                  mem_r [SETS];
  line_set_t                  rd_r;
  req_t                       req_r;
  logic [WAYS-1:0]            vrow_r;
  logic [31:0]                acc_r, hits_r, miss_r;
  logic                       hit;
  logic                       found_empty;
  wayidx_t                    sel;
  logic [31:0]                best;
  logic [31:0]                stamp;
  row_t                       wrow;

  always_comb begin
    hit = 1'b0;
    found_empty = 1'b0;
    sel = '0;
    best = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow_r[w] && rd_r[w][TAG_W+63:64] == req_r.tag) begin
        hit = 1'b1;
        sel = WAY_W'(w);
      end
    end
    if (!hit) begin
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!vrow_r[w]) begin
          found_empty = 1'b1;
          sel = WAY_W'(w);
        end
      end
      if (!found_empty) begin
        sel = '0;
        best = cfg_use_lru ? rd_r[0][63:32] : rd_r[0][31:0];
        for (int w = 1; w < WAYS; w++) begin
          stamp = cfg_use_lru ? rd_r[w][63:32] : rd_r[w][31:0];
          if (stamp < best) begin
            best = stamp;
            sel = WAY_W'(w);
          end
        end
      end
    end
    stamp = acc_r + 32'd1;
    wrow = {req_r.tag, stamp, hit ? rd_r[sel][31:0] : stamp};
  end

  assign q_pop = (state_r == S_READ) && q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= mem_r[q_req.set];
      req_r <= q_req;
      vrow_r <= valid_r[q_req.set];
    end
    if (state_r == S_UPD) begin
      mem_r[req_r.set][sel] <= wrow;
      out_hit <= hit;
      out_way <= 2'(sel);
      out_evicted <= !hit && !found_empty;
      out_hit_count <= hits_r + 32'(hit);
      out_miss_count <= miss_r + 32'(!hit);
    end
    if (!rst_n) begin
      state_r <= S_READ;
      valid_r <= '0;
      acc_r <= '0;
      hits_r <= '0;
      miss_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_READ: begin
          if (q_pop) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          valid_r[req_r.set][sel] <= 1'b1;
          acc_r <= acc_r + 32'd1;
          hits_r <= hits_r + 32'(hit);
          miss_r <= miss_r + 32'(!hit);
          out_valid <= 1'b1;
          state_r <= S_READ;
        end
        default: state_r <= S_READ;
      endcase
    end
  end
endmodule

FILE: src/set_assoc_cache_tag_lru_fifo.sv
// Tag store of a set-associative cache with LRU or FIFO replacement. Each address
// request goes through the lookup engine in order: it first reads the set's tags and
// stamps from the line store, then picks the way and writes it back; the engine
// takes no new request until that write-back is done. A two-entry queue sits
// between the address front end and the lookup engine, and results leave
// through an output register. use_lru should be written only while idle.
`include "assert_macros.svh"
module set_assoc_cache_tag_lru_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [1:0]  out_way,
  output logic        out_evicted,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count
);
  import sac_pkg::*;

  logic use_lru_r;
  logic q_valid, q_pop;
  req_t q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_lru_r <= 1'b1;
    end else if (cfg_we) begin
      use_lru_r <= cfg_wdata;
    end
  end

  sac_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_address(in_address), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  sac_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_use_lru(use_lru_r), .q_valid(q_valid),
    .q_pop(q_pop), .q_req(q_req), .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_way(out_way), .out_evicted(out_evicted),
    .out_hit_count(out_hit_count), .out_miss_count(out_miss_count)
  );

  `ASSERT_CLK(a_hit_no_evict, clk, rst_n, out_valid |-> !(out_hit && out_evicted), "hit with eviction")
  `ASSERT_NEXT(a_pop_valid, clk, rst_n, q_pop, !q_pop, "back-to-back pops")
  `ASSERT_CLK(a_pop_has_data, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
endmodule
